### rtl/core/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and constants of the sync/length/type deframer.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int MAX_LEN_W  = 24;
    localparam int TYPE_W     = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_TYPE   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_TYPE   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REQUEST_TYPE = 4'd3;

    // configuration reset values
    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RST      = 24'd240000;
    localparam logic [TYPE_W-1:0]    IMAGE_TYPE_RST   = 32'd1;
    localparam logic [TYPE_W-1:0]    COEFF_TYPE_RST   = 32'd2;
    localparam logic [TYPE_W-1:0]    REQUEST_TYPE_RST = 32'd3;

    // sync pattern 55 aa 00 00
    localparam logic [7:0] SYNC_BYTE0 = 8'h55;
    localparam logic [7:0] SYNC_BYTE1 = 8'haa;
    localparam logic [7:0] SYNC_BYTE2 = 8'h00;

    // packet kinds
    localparam logic [1:0] KIND_IMAGE   = 2'd0;
    localparam logic [1:0] KIND_COEFF   = 2'd1;
    localparam logic [1:0] KIND_REQUEST = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    // result queue between parser and output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [1:0] kind;
        logic       last;
        logic       empty_res;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } res_xfer_t;

endpackage

### rtl/core/slt_front.sv
// ----------------------------------------------------------------------------
// slt_front
// Byte parser: sync hunt, length and type fields, payload tagging.
// ----------------------------------------------------------------------------
module slt_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         rx_byte,
    input  logic                               cfg_we,
    input  logic [slt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [slt_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               queue_full,
    output slt_pkg::res_xfer_t                 push
);
    import slt_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN,
        PH_TYPE,
        PH_PAYLOAD,
        PH_SKIP,
        PH_TAIL
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [1:0]             sync_reg, sync_next;
    logic [1:0]             idx_reg, idx_next;
    logic [MAX_LEN_W-1:0]   len_reg, len_next;
    logic [23:0]            type_reg, type_next;
    logic [MAX_LEN_W-1:0]   left_reg, left_next;
    logic [1:0]             kind_reg, kind_next;
    logic [MAX_LEN_W-1:0]   max_len_reg, max_len_next;
    logic [TYPE_W-1:0]      image_type_reg, image_type_next;
    logic [TYPE_W-1:0]      coeff_type_reg, coeff_type_next;
    logic [TYPE_W-1:0]      request_type_reg, request_type_next;

    logic                   accept;
    logic [7:0]             sync_want;
    logic [TYPE_W-1:0]      full_type;
    logic [1:0]             type_kind;
    logic                   len_bad;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    always_comb
    begin
        unique case (sync_reg)
            2'd0:    sync_want = SYNC_BYTE0;
            2'd1:    sync_want = SYNC_BYTE1;
            default: sync_want = SYNC_BYTE2;
        endcase
    end

    // type word completes with the byte now arriving
    assign full_type = {rx_byte, type_reg};

    always_comb
    begin
        if (full_type == image_type_reg)
            type_kind = KIND_IMAGE;
        else if (full_type == coeff_type_reg)
            type_kind = KIND_COEFF;
        else if (full_type == request_type_reg)
            type_kind = KIND_REQUEST;
        else
            type_kind = KIND_NONE;
    end

    // a nonzero top byte is negative or beyond any 24-bit limit
    assign len_bad = (rx_byte != 8'd0) || (len_reg > max_len_reg);

    always_comb
    begin
        phase_next        = phase_reg;
        sync_next         = sync_reg;
        idx_next          = idx_reg;
        len_next          = len_reg;
        type_next         = type_reg;
        left_next         = left_reg;
        kind_next         = kind_reg;
        max_len_next      = max_len_reg;
        image_type_next   = image_type_reg;
        coeff_type_next   = coeff_type_reg;
        request_type_next = request_type_reg;
        push              = '0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_LEN:      max_len_next      = cfg_data[MAX_LEN_W-1:0];
                REG_IMAGE_TYPE:   image_type_next   = cfg_data;
                REG_COEFF_TYPE:   coeff_type_next   = cfg_data;
                REG_REQUEST_TYPE: request_type_next = cfg_data;
                default:          ;
            endcase
        end

        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == sync_want)
                    begin
                        if (sync_reg == 2'd3)
                        begin
                            phase_next = PH_LEN;
                            sync_next  = 2'd0;
                            idx_next   = 2'd0;
                        end
                        else
                        begin
                            sync_next = sync_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        sync_next = (rx_byte == SYNC_BYTE0) ? 2'd1 : 2'd0;
                    end
                end
                PH_LEN:
                begin
                    unique case (idx_reg)
                        2'd0: len_next[7:0]   = rx_byte;
                        2'd1: len_next[15:8]  = rx_byte;
                        2'd2: len_next[23:16] = rx_byte;
                        default: ;
                    endcase
                    if (idx_reg == 2'd3)
                    begin
                        idx_next = 2'd0;
                        if (len_bad)
                        begin
                            phase_next = PH_HUNT;
                            sync_next  = 2'd0;
                        end
                        else
                        begin
                            phase_next = PH_TYPE;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
                PH_TYPE:
                begin
                    unique case (idx_reg)
                        2'd0: type_next[7:0]   = rx_byte;
                        2'd1: type_next[15:8]  = rx_byte;
                        2'd2: type_next[23:16] = rx_byte;
                        default: ;
                    endcase
                    if (idx_reg == 2'd3)
                    begin
                        idx_next  = 2'd0;
                        left_next = len_reg;
                        if (len_reg == '0)
                        begin
                            phase_next = PH_TAIL;
                            if (type_kind != KIND_NONE)
                            begin
                                kind_next                = type_kind;
                                push.valid               = 1'b1;
                                push.data.payload_byte   = 8'd0;
                                push.data.kind           = type_kind;
                                push.data.last           = 1'b1;
                                push.data.empty_res      = 1'b1;
                            end
                        end
                        else if (type_kind == KIND_NONE)
                        begin
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            kind_next  = type_kind;
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
                PH_PAYLOAD:
                begin
                    left_next              = left_reg - MAX_LEN_W'(1);
                    push.valid             = 1'b1;
                    push.data.payload_byte = rx_byte;
                    push.data.kind         = kind_reg;
                    push.data.last         = (left_reg == MAX_LEN_W'(1));
                    push.data.empty_res    = 1'b0;
                    if (left_reg == MAX_LEN_W'(1))
                    begin
                        phase_next = PH_TAIL;
                        idx_next   = 2'd0;
                    end
                end
                PH_SKIP:
                begin
                    left_next = left_reg - MAX_LEN_W'(1);
                    if (left_reg == MAX_LEN_W'(1))
                    begin
                        phase_next = PH_TAIL;
                        idx_next   = 2'd0;
                    end
                end
                PH_TAIL:
                begin
                    if (idx_reg == 2'd3)
                    begin
                        idx_next   = 2'd0;
                        phase_next = PH_HUNT;
                        sync_next  = 2'd0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    sync_next  = 2'd0;
                    idx_next   = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            sync_reg         <= 2'd0;
            idx_reg          <= 2'd0;
            len_reg          <= '0;
            type_reg         <= '0;
            left_reg         <= '0;
            kind_reg         <= KIND_IMAGE;
            max_len_reg      <= MAX_LEN_RST;
            image_type_reg   <= IMAGE_TYPE_RST;
            coeff_type_reg   <= COEFF_TYPE_RST;
            request_type_reg <= REQUEST_TYPE_RST;
        end
        else
        begin
            phase_reg        <= phase_next;
            sync_reg         <= sync_next;
            idx_reg          <= idx_next;
            len_reg          <= len_next;
            type_reg         <= type_next;
            left_reg         <= left_next;
            kind_reg         <= kind_next;
            max_len_reg      <= max_len_next;
            image_type_reg   <= image_type_next;
            coeff_type_reg   <= coeff_type_next;
            request_type_reg <= request_type_next;
        end
    end

endmodule

### rtl/core/slt_queue.sv
// ----------------------------------------------------------------------------
// slt_queue
// Short result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module slt_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  slt_pkg::res_xfer_t  push,
    input  logic                pop,
    output logic                full,
    output slt_pkg::res_xfer_t  head
);
    import slt_pkg::*;

    result_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]    count_reg, count_next;
    logic                 do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.data  = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = push.valid ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (!push.valid && do_pop)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            entry_reg[wr_ptr_reg] <= push.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/core/slt_back.sv
// ----------------------------------------------------------------------------
// slt_back
// Output register stage: moves queued results onto the output channel.
// ----------------------------------------------------------------------------
module slt_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  slt_pkg::res_xfer_t  head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          payload_byte,
    output logic [1:0]          kind,
    output logic                last,
    output logic                empty_res
);
    import slt_pkg::*;

    logic       out_valid_reg, out_valid_next;
    result_t    out_data_reg;

    // refill when the register is empty or its transaction completes now
    assign pop = head.valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_data_reg <= head.data;
    end

    assign out_valid    = out_valid_reg;
    assign payload_byte = out_data_reg.payload_byte;
    assign kind         = out_data_reg.kind;
    assign last         = out_data_reg.last;
    assign empty_res    = out_data_reg.empty_res;

endmodule

### rtl/core/sync_length_type_deframer.sv
// ----------------------------------------------------------------------------
// sync_length_type_deframer
// Takes one link byte per cycle; a byte is never stalled unless the
// four-entry result queue is full, which only happens under output stall.
// A result is registered in the result queue and then in the output register.
// Reset is asynchronous: parser returns to sync hunt, queue and output
// register empty, configuration registers take their default values.
// ----------------------------------------------------------------------------
module sync_length_type_deframer
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         rx_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [7:0]                         payload_byte,
    output logic [1:0]                         kind,
    output logic                               last,
    output logic                               empty_res,
    input  logic                               cfg_we,
    input  logic [slt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [slt_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import slt_pkg::*;

    res_xfer_t  push;
    res_xfer_t  head;
    logic       queue_full;
    logic       pop;

    slt_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .push       (push)
    );

    slt_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (queue_full),
        .head  (head)
    );

    slt_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .payload_byte (payload_byte),
        .kind         (kind),
        .last         (last),
        .empty_res    (empty_res)
    );

endmodule

### tb/sv/sync_length_type_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_type_deframer_tb
// Drives link bytes into the deframer under random source gaps and sink
// stalls, and checks every payload transaction against a predictor of the
// sync hunt, length and type parsing and payload handling. A short table of
// hand-written bytes comes first, then random packets over several register
// settings, among them the extremes and overlapping type codes.
// ----------------------------------------------------------------------------
module sync_length_type_deframer_tb;

    import slt_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int ITEM_TARGET   = 1550;
    localparam int PHASE_ITEMS   = 200;
    localparam int MAX_SHORT     = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [31:0] SYNC_WORD = {SYNC_BYTE2, SYNC_BYTE2, SYNC_BYTE1, SYNC_BYTE0};

    typedef enum logic [2:0] {
        SEEK_SYNC,
        READ_LEN,
        READ_TYPE,
        PASS_PAYLOAD,
        DROP_PAYLOAD,
        SKIP_TAIL
    } link_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        result_t    res;
    } link_item_t;

    // directed bytes: partial sync restart, empty coefficient packet, a tail
    // that looks like sync, then a negative length that must be dropped
    localparam link_item_t DIRECTED [25] = '{
        '{8'h55, 1'b0, '0}, '{8'h55, 1'b0, '0}, '{8'haa, 1'b0, '0},
        '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h02, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, '{8'h00, KIND_COEFF, 1'b1, 1'b1}},
        '{8'h55, 1'b0, '0}, '{8'haa, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h55, 1'b0, '0}, '{8'haa, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hff, 1'b0, '0}, '{8'hff, 1'b0, '0}, '{8'hff, 1'b0, '0},
        '{8'hff, 1'b0, '0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            rx_byte = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [7:0]            payload_byte;
    logic [1:0]            kind;
    logic                  last;
    logic                  empty_res;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // hand-typed expectation travelling with the byte
    logic    row_typed = 1'b0;
    result_t row_res = '0;

    // predictor state and register copies
    link_phase_t link_phase  = SEEK_SYNC;
    logic [1:0]  sync_seen   = '0;
    logic [1:0]  word_byte   = '0;
    logic [31:0] len_acc     = '0;
    logic [31:0] type_acc    = '0;
    logic [23:0] remaining   = '0;
    logic [1:0]  pkt_kind    = '0;
    logic [23:0] len_limit   = MAX_LEN_RST;
    logic [31:0] image_code  = IMAGE_TYPE_RST;
    logic [31:0] coeff_code  = COEFF_TYPE_RST;
    logic [31:0] request_code = REQUEST_TYPE_RST;

    result_t    due_results [$];
    link_item_t link_stream [$];

    int unsigned items_sent     = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned gap_pct        = 0;
    int unsigned stall_pct      = 0;

    sync_length_type_deframer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .payload_byte (payload_byte),
        .kind         (kind),
        .last         (last),
        .empty_res    (empty_res),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // advances the parser by one byte; returns 1 when the byte yields a result
    function automatic logic deframe_byte(input logic [7:0] b, output result_t res);
        logic [7:0] want;
        logic [1:0] k;
        res = '0;
        deframe_byte = 1'b0;
        case (link_phase)
            SEEK_SYNC:
            begin
                want = (sync_seen == 2'd0) ? SYNC_BYTE0 :
                       (sync_seen == 2'd1) ? SYNC_BYTE1 : SYNC_BYTE2;
                if (b == want && sync_seen == 2'd3)
                begin
                    sync_seen  = '0;
                    link_phase = READ_LEN;
                    word_byte  = '0;
                    len_acc    = '0;
                end
                else if (b == want)
                    sync_seen = sync_seen + 2'd1;
                else
                    sync_seen = (b == SYNC_BYTE0) ? 2'd1 : 2'd0;
            end
            READ_LEN:
            begin
                len_acc[8*word_byte +: 8] = b;
                if (word_byte == 2'd3)
                begin
                    word_byte = '0;
                    if (len_acc[31] || len_acc > {8'd0, len_limit})
                    begin
                        link_phase = SEEK_SYNC;
                        sync_seen  = '0;
                    end
                    else
                    begin
                        link_phase = READ_TYPE;
                        type_acc   = '0;
                    end
                end
                else
                    word_byte = word_byte + 2'd1;
            end
            READ_TYPE:
            begin
                type_acc[8*word_byte +: 8] = b;
                if (word_byte != 2'd3)
                    word_byte = word_byte + 2'd1;
                else
                begin
                    word_byte = '0;
                    // image beats coefficient beats request on equal codes
                    if (type_acc == image_code)
                        k = KIND_IMAGE;
                    else if (type_acc == coeff_code)
                        k = KIND_COEFF;
                    else if (type_acc == request_code)
                        k = KIND_REQUEST;
                    else
                        k = KIND_NONE;
                    remaining = len_acc[23:0];
                    if (remaining == '0)
                    begin
                        link_phase = SKIP_TAIL;
                        if (k != KIND_NONE)
                        begin
                            pkt_kind     = k;
                            res          = {8'h00, k, 1'b1, 1'b1};
                            deframe_byte = 1'b1;
                        end
                    end
                    else if (k == KIND_NONE)
                        link_phase = DROP_PAYLOAD;
                    else
                    begin
                        pkt_kind   = k;
                        link_phase = PASS_PAYLOAD;
                    end
                end
            end
            PASS_PAYLOAD:
            begin
                remaining    = remaining - 24'd1;
                res          = {b, pkt_kind, remaining == '0, 1'b0};
                deframe_byte = 1'b1;
                if (remaining == '0)
                begin
                    link_phase = SKIP_TAIL;
                    word_byte  = '0;
                end
            end
            DROP_PAYLOAD:
            begin
                remaining = remaining - 24'd1;
                if (remaining == '0)
                begin
                    link_phase = SKIP_TAIL;
                    word_byte  = '0;
                end
            end
            SKIP_TAIL:
            begin
                if (word_byte == 2'd3)
                begin
                    word_byte  = '0;
                    link_phase = SEEK_SYNC;
                    sync_seen  = '0;
                end
                else
                    word_byte = word_byte + 2'd1;
            end
            default:
            begin
                link_phase = SEEK_SYNC;
                sync_seen  = '0;
                word_byte  = '0;
            end
        endcase
    endfunction

    task automatic log_mismatch(input string why, input result_t want, input result_t seen);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch, %s: expected byte %02h kind %0d last %0d empty %0d, "
                     , why, want.payload_byte, want.kind, want.last, want.empty_res,
                     "got byte %02h kind %0d last %0d empty %0d",
                     seen.payload_byte, seen.kind, seen.last, seen.empty_res);
    endtask

    always @(posedge clk)
    begin : link_watch
        result_t seen;
        result_t want;
        result_t pred;
        logic    has_res;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen = {payload_byte, kind, last, empty_res};
                if (due_results.size() == 0)
                    log_mismatch("no result due", '0, seen);
                else
                begin
                    want = due_results.pop_front();
                    if (seen !== want)
                        log_mismatch("field differs", want, seen);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAX_LEN:      len_limit    = cfg_data[MAX_LEN_W-1:0];
                    REG_IMAGE_TYPE:   image_code   = cfg_data;
                    REG_COEFF_TYPE:   coeff_code   = cfg_data;
                    REG_REQUEST_TYPE: request_code = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                has_res = deframe_byte(rx_byte, pred);
                if (row_typed)
                    due_results.insert(due_results.size(), row_res);
                else if (has_res)
                    due_results.insert(due_results.size(), pred);
            end
        end
    end

    // sink stalls in random bursts
    initial
    begin : sink_stall
        forever
        begin
            @(posedge clk);
            if (stall_pct != 0 && $urandom_range(99) < stall_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(13, 1)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_link(input link_item_t it);
        in_valid  <= 1'b1;
        rx_byte   <= it.data;
        row_typed <= it.typed;
        row_res   <= it.res;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(13, 1)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        if (in_valid)
            in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        // bytes with no result may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [31:0] lim, input logic [31:0] img,
                                input logic [31:0] coef, input logic [31:0] req);
        write_reg(REG_MAX_LEN, lim);
        write_reg(REG_IMAGE_TYPE, img);
        write_reg(REG_COEFF_TYPE, coef);
        write_reg(REG_REQUEST_TYPE, req);
        if ($urandom_range(1))
            write_reg(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, REG_REQUEST_TYPE + 1)),
                      $urandom);
        cfg_we <= 1'b0;
        // let the register copies settle before packets are built from them
        @(posedge clk);
    endtask

    task automatic push_byte(input logic [7:0] b);
        link_stream.insert(link_stream.size(), {b, 1'b0, result_t'('0)});
    endtask

    task automatic push_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            push_byte(w[8*i +: 8]);
    endtask

    // one packet, mostly well formed, sometimes noise or a bad length
    task automatic queue_packet();
        int unsigned r;
        int unsigned n;
        logic [7:0]  junk;
        logic [31:0] len_w;
        logic [31:0] type_w;
        logic [31:0] lim_w;
        lim_w = {8'd0, len_limit};
        if ($urandom_range(99) < 12)
        begin
            repeat ($urandom_range(8, 1)) push_byte(8'($urandom_range(255)));
            return;
        end
        // broken sync ahead of the real one
        if ($urandom_range(3) == 0)
        begin
            n = $urandom_range(3, 1);
            for (int i = 0; i < n; i++)
                push_byte(SYNC_WORD[8*i +: 8]);
            if ($urandom_range(1))
            begin
                junk = 8'($urandom_range(255));
                push_byte((junk == SYNC_WORD[8*n +: 8]) ? ~junk : junk);
            end
        end
        push_word(SYNC_WORD);
        r = $urandom_range(99);
        if (r < 8)
            len_w = {1'b1, 31'($urandom)};
        else if (r < 16)
        begin
            len_w = $urandom_range(1) ? lim_w + 32'd1 : ($urandom & 32'h7fff_ffff);
            if (len_w <= lim_w)
                len_w = lim_w + 32'd1;
        end
        else if (r < 26 || lim_w == 0)
            len_w = 0;
        else if (r < 32 && lim_w <= MAX_SHORT)
            len_w = lim_w;
        else
            len_w = $urandom_range((lim_w < MAX_SHORT) ? lim_w : MAX_SHORT, 1);
        push_word(len_w);
        if (len_w[31] || len_w > lim_w)
        begin
            repeat ($urandom_range(4)) push_byte(8'($urandom_range(255)));
            return;
        end
        r = $urandom_range(99);
        if (r < 30)
            type_w = image_code;
        else if (r < 55)
            type_w = coeff_code;
        else if (r < 80)
            type_w = request_code;
        else if (r < 90)
            type_w = image_code ^ (32'd1 << $urandom_range(31));
        else
            type_w = $urandom;
        push_word(type_w);
        for (int i = 0; i < len_w; i++)
            push_byte(8'($urandom_range(255)));
        push_word($urandom_range(3) == 0 ? SYNC_WORD : $urandom);
    endtask

    initial
    begin : stimulus
        int unsigned phase_no;
        logic [31:0] shared;
        logic        calm;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values apply to the table
        foreach (DIRECTED[i])
            send_link(DIRECTED[i]);
        wait_drained();

        phase_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            calm = (items_sent + PHASE_ITEMS >= ITEM_TARGET);
            shared = $urandom;
            case (phase_no)
                0: program_regs(32'hffff_ffff, $urandom, $urandom, $urandom);
                1: program_regs(32'd0, 32'd0, 32'hffff_ffff, $urandom);
                2: program_regs($urandom_range(40, 1), shared, shared, shared);
                3: program_regs($urandom_range(200000), 32'hffff_ffff, shared, shared);
                4: program_regs(32'(MAX_LEN_RST), IMAGE_TYPE_RST, COEFF_TYPE_RST,
                                REQUEST_TYPE_RST);
                default: program_regs($urandom_range(1) ? $urandom_range(64) : $urandom,
                                      $urandom, $urandom, $urandom);
            endcase
            case ($urandom_range(3))
                0: gap_pct = 0;
                1: gap_pct = 5;
                2: gap_pct = 15;
                default: gap_pct = 30;
            endcase
            stall_pct = $urandom_range(3) * 10;
            if (calm)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            while (link_stream.size() < PHASE_ITEMS)
                queue_packet();
            while (link_stream.size() != 0)
                send_link(link_stream.pop_front());
            wait_drained();
            phase_no++;
        end

        if (mismatch_count == 0 && due_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
